// ----- hdl/mtf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants of the move-to-front key list.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int KEY_W = 64;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_MAX = 4'd15;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             ignored;
  } result_t;

endpackage

// ----- hdl/mtf_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_match
// Parallel key compare with a lowest-index priority pick and result coding.
// ----------------------------------------------------------------------------
module mtf_match #(
  parameter int DEPTH = 8,
  parameter int HIT_W = $clog2(DEPTH + 1)
) (
  input  mtf_pkg::key_t   keys [DEPTH],
  input  logic            action,
  input  mtf_pkg::key_t   key,
  output logic [HIT_W-1:0] hit,
  output logic            record,
  output mtf_pkg::result_t res
);

  logic [DEPTH-1:0]   match;
  logic               skip;
  logic [HIT_W+3:0]   hit_ext;
  logic [HIT_W+3:0]   pos_src;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (keys[i] == key);
    end
  end

  always_comb begin
    hit = HIT_W'(DEPTH);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = HIT_W'(i);
      end
    end
  end

  assign skip    = (action == mtf_pkg::ACT_RECORD) && (key == '0);
  assign record  = (action == mtf_pkg::ACT_RECORD) && !skip;
  assign hit_ext = {4'b0000, hit};
  assign pos_src = skip ? (HIT_W + 4)'(DEPTH) : hit_ext;

  always_comb begin
    res.found   = !skip && (match != '0);
    res.ignored = skip;
    if (pos_src > (HIT_W + 4)'(mtf_pkg::POS_MAX)) begin
      res.position = mtf_pkg::POS_MAX;
    end else begin
      res.position = pos_src[mtf_pkg::POS_W-1:0];
    end
  end

endmodule

// ----- hdl/mtf_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_list
// Key storage row; on an update the entries up to the hit index shift down
// one place and the new key enters at the front.
// ----------------------------------------------------------------------------
module mtf_list #(
  parameter int DEPTH = 8,
  parameter int HIT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  logic [HIT_W-1:0] hit,
  input  mtf_pkg::key_t    key,
  output mtf_pkg::key_t    keys [DEPTH]
);

  mtf_pkg::key_t entries [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= '0;
      end
    end else if (update) begin
      entries[0] <= key;
      for (int i = 1; i < DEPTH; i++) begin
        if (HIT_W'(i) <= hit) begin
          entries[i] <= entries[i-1];
        end
      end
    end
  end

  assign keys = entries;

endmodule

// ----- hdl/move_to_front_key_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_key_list
// Most-recent-first list of 64-bit keys with record and query beats.
// ----------------------------------------------------------------------------
// Flow: a beat accepted into the input register moves on to the result
// register when the result register is free or not stalled.
// Throughput: one beat per cycle unless rsp_stall holds the result; the
// compare and list shift both lie between the input and result registers.
// Reset empties both registers and clears every list entry to zero.
// ----------------------------------------------------------------------------
module move_to_front_key_list #(
  parameter int LIST_DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         action,
  input  logic [mtf_pkg::KEY_W-1:0]    key,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         found,
  output logic [mtf_pkg::POS_W-1:0]    position,
  output logic                         ignored
);

  localparam int HIT_W = $clog2(LIST_DEPTH + 1);

  logic             in_valid;
  logic             in_action;
  mtf_pkg::key_t    in_key;
  logic             advance;
  logic             fire;
  logic [HIT_W-1:0] hit;
  logic             record;
  mtf_pkg::result_t res;
  mtf_pkg::key_t    keys [LIST_DEPTH];

  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = in_valid && advance;
  assign req_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      in_action <= action;
      in_key    <= key;
    end
  end

  mtf_match #(
    .DEPTH (LIST_DEPTH),
    .HIT_W (HIT_W)
  ) u_match (
    .keys   (keys),
    .action (in_action),
    .key    (in_key),
    .hit    (hit),
    .record (record),
    .res    (res)
  );

  mtf_list #(
    .DEPTH (LIST_DEPTH),
    .HIT_W (HIT_W)
  ) u_list (
    .clk    (clk),
    .rst    (rst),
    .update (fire && record),
    .hit    (hit),
    .key    (in_key),
    .keys   (keys)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      found    <= res.found;
      position <= res.position;
      ignored  <= res.ignored;
    end
  end

  a_front_written : assert property (@(posedge clk) disable iff (rst)
    (fire && record) |=> (keys[0] == $past(in_key)))
    else $error("recorded key did not reach the front of the list");

  a_ignored_clean : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && ignored) |-> !found)
    else $error("skipped record reported a hit");

  a_miss_code : assert property (@(posedge clk) disable iff (rst)
    (fire && !res.found && !res.ignored) |=> (rsp_valid && !found))
    else $error("miss not carried to the result register");

  a_skip_keeps_list : assert property (@(posedge clk) disable iff (rst)
    (fire && res.ignored) |=> (keys[0] == $past(keys[0])))
    else $error("skipped record changed the list");

endmodule
